FILE: rtl/soa_pkg.sv
// Shared types and constants of the slab object allocator.
`default_nettype none
package soa_pkg;

  localparam int OBJ_SIZE_W = 12;
  localparam int SLOTS_W    = 11;
  localparam int ADDR_W     = 16;
  localparam int CHAIN_W    = 12;
  localparam int DIVISOR_W  = 17;
  localparam int DIV_STEPS  = 16;
  localparam int DIV_CNT_W  = 5;

  localparam logic [OBJ_SIZE_W-1:0] OBJ_SIZE_RESET = 12'd16;
  localparam logic [SLOTS_W-1:0]    OBJ_PER_SLAB_RESET = 11'd227;
  localparam logic [CHAIN_W-1:0]    END_SLOT = 12'hFFF;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_SHRINK = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_PAGE  = 2'd1;
  localparam logic [1:0] STATUS_BAD_ADDR = 2'd2;

  localparam logic [1:0] TAG_UNOWNED = 2'd0;
  localparam logic [1:0] TAG_FREE    = 2'd1;
  localparam logic [1:0] TAG_PARTIAL = 2'd2;
  localparam logic [1:0] TAG_FULL    = 2'd3;

  localparam logic CFG_OBJECT_SIZE      = 1'b0;
  localparam logic CFG_OBJECTS_PER_SLAB = 1'b1;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [ADDR_W-1:0] object_address;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] allocated_address;
    logic [4:0]        slabs_released;
  } rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH, ST_A_PICK, ST_A_SCAN, ST_A_CHAIN, ST_A_UNLINK, ST_A_POP,
    ST_A_WAIT, ST_A_ADDR, ST_F_CHECK1, ST_F_WAIT2, ST_F_CHECK2,
    ST_F_UNLINK, ST_F_PUSH, ST_S_WALK, ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    C_NONE, C_LOAD, C_PICK, C_SCAN, C_CHAIN, C_UNLINK, C_POP, C_LINK, C_ADDR,
    C_CHECK1, C_CHECK2, C_FREE_UNLINK, C_FREE_PUSH, C_WALK, C_EMIT
  } cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       have_slab;
    logic       n_zero;
    logic       scan_hit;
    logic       scan_last;
    logic       chain_last;
    logic       pop_empty;
    logic       div_busy;
    logic       free_bad;
    logic       slot_bad;
    logic       walk_more;
    logic       rsp_free;
  } dp_status_t;

endpackage
`default_nettype wire

FILE: rtl/soa_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module soa_div (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [soa_pkg::ADDR_W-1:0]        dividend,
  input  wire logic [soa_pkg::DIVISOR_W-1:0]     divisor,
  output logic                                   busy,
  output logic [soa_pkg::ADDR_W-1:0]             quotient,
  output logic [soa_pkg::DIVISOR_W-1:0]          remainder
);

  logic [soa_pkg::DIV_CNT_W-1:0] cnt;
  logic [soa_pkg::DIVISOR_W:0]   trial;
  logic                          ge;

  assign trial = {remainder, quotient[soa_pkg::ADDR_W-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign busy  = cnt != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= soa_pkg::DIV_CNT_W'(soa_pkg::DIV_STEPS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      quotient  <= dividend;
    end else if (busy) begin
      remainder <= ge ? soa_pkg::DIVISOR_W'(trial - {1'b0, divisor})
                      : trial[soa_pkg::DIVISOR_W-1:0];
      quotient  <= {quotient[soa_pkg::ADDR_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

FILE: rtl/soa_ctrl.sv
// Sequencer that steps the allocator datapath through each operation.
`default_nettype none
module soa_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  input  wire soa_pkg::dp_status_t st,
  output logic                     req_stall,
  output soa_pkg::cmd_t            cmd
);

  soa_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= soa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      soa_pkg::ST_IDLE: begin
        if (req_valid) state_next = soa_pkg::ST_DISPATCH;
      end
      soa_pkg::ST_DISPATCH: begin
        case (st.opcode)
          soa_pkg::OP_ALLOC:  state_next = soa_pkg::ST_A_PICK;
          soa_pkg::OP_FREE:   state_next = soa_pkg::ST_F_CHECK1;
          soa_pkg::OP_SHRINK: state_next = soa_pkg::ST_S_WALK;
          default:            state_next = soa_pkg::ST_DONE;
        endcase
      end
      soa_pkg::ST_A_PICK: begin
        if (st.have_slab) state_next = soa_pkg::ST_A_UNLINK;
        else if (st.n_zero) state_next = soa_pkg::ST_DONE;
        else state_next = soa_pkg::ST_A_SCAN;
      end
      soa_pkg::ST_A_SCAN: begin
        if (st.scan_hit) state_next = soa_pkg::ST_A_CHAIN;
        else if (st.scan_last) state_next = soa_pkg::ST_DONE;
      end
      soa_pkg::ST_A_CHAIN: begin
        if (st.chain_last) state_next = soa_pkg::ST_A_POP;
      end
      soa_pkg::ST_A_UNLINK: state_next = soa_pkg::ST_A_POP;
      soa_pkg::ST_A_POP: begin
        state_next = st.pop_empty ? soa_pkg::ST_DONE : soa_pkg::ST_A_WAIT;
      end
      soa_pkg::ST_A_WAIT:   state_next = soa_pkg::ST_A_ADDR;
      soa_pkg::ST_A_ADDR:   state_next = soa_pkg::ST_DONE;
      soa_pkg::ST_F_CHECK1: begin
        state_next = st.free_bad ? soa_pkg::ST_DONE : soa_pkg::ST_F_WAIT2;
      end
      soa_pkg::ST_F_WAIT2: begin
        if (!st.div_busy) state_next = soa_pkg::ST_F_CHECK2;
      end
      soa_pkg::ST_F_CHECK2: begin
        state_next = st.slot_bad ? soa_pkg::ST_DONE : soa_pkg::ST_F_UNLINK;
      end
      soa_pkg::ST_F_UNLINK: state_next = soa_pkg::ST_F_PUSH;
      soa_pkg::ST_F_PUSH:   state_next = soa_pkg::ST_DONE;
      soa_pkg::ST_S_WALK: begin
        if (!st.walk_more) state_next = soa_pkg::ST_DONE;
      end
      soa_pkg::ST_DONE: begin
        if (st.rsp_free) state_next = soa_pkg::ST_IDLE;
      end
      default: state_next = soa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_stall = state != soa_pkg::ST_IDLE;
    cmd = soa_pkg::C_NONE;
    case (state)
      soa_pkg::ST_IDLE:     cmd = req_valid ? soa_pkg::C_LOAD : soa_pkg::C_NONE;
      soa_pkg::ST_A_PICK:   cmd = soa_pkg::C_PICK;
      soa_pkg::ST_A_SCAN:   cmd = soa_pkg::C_SCAN;
      soa_pkg::ST_A_CHAIN:  cmd = soa_pkg::C_CHAIN;
      soa_pkg::ST_A_UNLINK: cmd = soa_pkg::C_UNLINK;
      soa_pkg::ST_A_POP:    cmd = soa_pkg::C_POP;
      soa_pkg::ST_A_WAIT:   cmd = soa_pkg::C_LINK;
      soa_pkg::ST_A_ADDR:   cmd = soa_pkg::C_ADDR;
      soa_pkg::ST_F_CHECK1: cmd = soa_pkg::C_CHECK1;
      soa_pkg::ST_F_CHECK2: cmd = soa_pkg::C_CHECK2;
      soa_pkg::ST_F_UNLINK: cmd = soa_pkg::C_FREE_UNLINK;
      soa_pkg::ST_F_PUSH:   cmd = soa_pkg::C_FREE_PUSH;
      soa_pkg::ST_S_WALK:   cmd = soa_pkg::C_WALK;
      soa_pkg::ST_DONE:     cmd = st.rsp_free ? soa_pkg::C_EMIT : soa_pkg::C_NONE;
      default:              cmd = soa_pkg::C_NONE;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/soa_dpath.sv
// Allocator datapath: page lists, slot chain memory, divider and result word.
`default_nettype none
module soa_dpath #(
  parameter int POOL_PAGES = 16,
  parameter int PAGE_BYTES = 4096,
  parameter int MAX_SLOTS  = 2048
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire soa_pkg::cmd_t        cmd,
  output soa_pkg::dp_status_t       st,
  input  wire soa_pkg::req_t        req,
  output soa_pkg::rsp_t             rsp,
  output logic                      rsp_valid,
  input  wire logic                 rsp_stall,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_index,
  input  wire logic [15:0]          cfg_data
);

  localparam int PIW   = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int LW    = $clog2(POOL_PAGES + 1);
  localparam int CW    = $clog2(POOL_PAGES + 1);
  localparam int DEPTH = POOL_PAGES * MAX_SLOTS;
  localparam int CAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PGW   = $clog2(PAGE_BYTES);
  localparam logic [LW-1:0] NIL = LW'(POOL_PAGES);
  localparam int SW = soa_pkg::SLOTS_W;

  // Configuration.
  logic [soa_pkg::OBJ_SIZE_W-1:0] osz;
  logic [SW-1:0]                  ops;
  logic [SW-1:0]                  n;

  // Per-page records and list heads.
  logic [1:0]                  tag  [POOL_PAGES];
  logic [SW-1:0]               uses [POOL_PAGES];
  logic [soa_pkg::CHAIN_W-1:0] fhead[POOL_PAGES];
  logic [LW-1:0]               nxt  [POOL_PAGES];
  logic [LW-1:0]               prv  [POOL_PAGES];
  logic [LW-1:0]               head [3];

  logic [soa_pkg::CHAIN_W-1:0] chain [DEPTH];
  logic [soa_pkg::CHAIN_W-1:0] chain_rdata;
  logic [CAW-1:0]              chain_raddr;
  logic [CAW-1:0]              chain_waddr;
  logic [soa_pkg::CHAIN_W-1:0] chain_wdata;
  logic                        chain_we;

  // Operation registers.
  logic [1:0]                  op;
  logic [soa_pkg::ADDR_W-1:0]  addr;
  logic [PIW-1:0]              p;
  logic [PIW-1:0]              scan;
  logic [SW-1:0]               j;
  logic [SW-1:0]               slot;
  logic [soa_pkg::CHAIN_W-1:0] h;
  logic [23:0]                 prod;
  logic [LW-1:0]               cur;
  logic [CW-1:0]               cnt;
  soa_pkg::rsp_t               res;

  // Divider.
  logic                            div_start;
  logic                            div_busy;
  logic [soa_pkg::ADDR_W-1:0]      div_dividend;
  logic [soa_pkg::DIVISOR_W-1:0]   div_divisor;
  logic [soa_pkg::ADDR_W-1:0]      dq;
  logic [soa_pkg::DIVISOR_W-1:0]   dr;

  logic [soa_pkg::ADDR_W-1:0] pg;
  logic [soa_pkg::ADDR_W-1:0] off;
  logic [soa_pkg::ADDR_W-1:0] d;
  logic [PIW-1:0]             qi;
  logic                       free_bad;
  logic                       chain_last;
  logic                       pop_empty;
  logic                       have_slab;
  logic [PIW-1:0]             pick;
  logic [1:0]                 push_t;
  logic [LW-1:0]              push_h;
  logic [LW-1:0]              ul_nx;
  logic [LW-1:0]              ul_pv;
  logic [1:0]                 ul_t;
  logic                       rsp_free;

  assign n = (32'(ops) < MAX_SLOTS) ? ops : SW'(MAX_SLOTS);

  soa_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .quotient  (dq),
    .remainder (dr)
  );

  // Pages are a power of two in size, so page and offset are plain bit fields.
  assign pg  = soa_pkg::ADDR_W'(32'(addr) >> PGW);
  assign off = soa_pkg::ADDR_W'(32'(addr) & (PAGE_BYTES - 1));
  assign d   = soa_pkg::ADDR_W'(off - soa_pkg::ADDR_W'({n, 1'b0}));
  assign qi  = pg[PIW-1:0];
  assign free_bad = (32'(pg) >= POOL_PAGES) || (tag[qi] == soa_pkg::TAG_UNOWNED) ||
                    (osz == '0) || (off < soa_pkg::ADDR_W'({n, 1'b0})) ||
                    (uses[qi] == '0);

  assign div_start    = (cmd == soa_pkg::C_CHECK1) && !free_bad;
  assign div_dividend = d;
  assign div_divisor  = soa_pkg::DIVISOR_W'(osz);

  assign have_slab  = (head[1] != NIL) || (head[0] != NIL);
  assign pick       = (head[1] != NIL) ? head[1][PIW-1:0] : head[0][PIW-1:0];
  assign chain_last = (12'(j) + 12'd1) == 12'(n);
  assign pop_empty  = fhead[p] >= 12'(n);
  assign ul_nx = nxt[p];
  assign ul_pv = prv[p];
  assign ul_t  = tag[p];
  assign rsp_free = !rsp_valid || !rsp_stall;

  always_comb begin
    case (cmd)
      soa_pkg::C_POP:       push_t = soa_pkg::TAG_FULL;
      soa_pkg::C_LINK:      push_t = (uses[p] >= n) ? soa_pkg::TAG_FULL : soa_pkg::TAG_PARTIAL;
      soa_pkg::C_FREE_PUSH: push_t = (uses[p] == '0) ? soa_pkg::TAG_FREE
                                                      : soa_pkg::TAG_PARTIAL;
      default:              push_t = soa_pkg::TAG_FREE;
    endcase
  end
  assign push_h = head[push_t - 2'd1];

  assign chain_raddr = CAW'(32'(p) * MAX_SLOTS + 32'(fhead[p][SW-1:0]));
  assign chain_we    = (cmd == soa_pkg::C_CHAIN) || (cmd == soa_pkg::C_FREE_UNLINK);
  assign chain_waddr = (cmd == soa_pkg::C_CHAIN) ? CAW'(32'(p) * MAX_SLOTS + 32'(j))
                                                 : CAW'(32'(p) * MAX_SLOTS + 32'(slot));
  assign chain_wdata = (cmd == soa_pkg::C_CHAIN)
                         ? (chain_last ? soa_pkg::END_SLOT : 12'(j) + 12'd1)
                         : fhead[p];

  always_ff @(posedge clk) begin
    if (chain_we) chain[chain_waddr] <= chain_wdata;
    chain_rdata <= chain[chain_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      osz <= soa_pkg::OBJ_SIZE_RESET;
      ops <= soa_pkg::OBJ_PER_SLAB_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == soa_pkg::CFG_OBJECT_SIZE) osz <= cfg_data[soa_pkg::OBJ_SIZE_W-1:0];
      else ops <= cfg_data[SW-1:0];
    end
  end

  // Page records; only ownership tags and list heads are cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < POOL_PAGES; i++) tag[i] <= soa_pkg::TAG_UNOWNED;
      for (int i = 0; i < 3; i++) head[i] <= NIL;
    end else begin
      case (cmd)
        soa_pkg::C_CHAIN: begin
          if (chain_last) begin
            uses[p]  <= '0;
            fhead[p] <= '0;
          end
        end
        soa_pkg::C_UNLINK, soa_pkg::C_FREE_UNLINK: begin
          if (ul_pv != NIL) nxt[ul_pv[PIW-1:0]] <= ul_nx;
          else head[ul_t - 2'd1] <= ul_nx;
          if (ul_nx != NIL) prv[ul_nx[PIW-1:0]] <= ul_pv;
          tag[p] <= soa_pkg::TAG_UNOWNED;
          if (cmd == soa_pkg::C_FREE_UNLINK) begin
            fhead[p] <= 12'(slot);
            uses[p]  <= uses[p] - 1'b1;
          end
        end
        soa_pkg::C_POP, soa_pkg::C_LINK, soa_pkg::C_FREE_PUSH: begin
          if (cmd == soa_pkg::C_POP && !pop_empty) begin
            uses[p] <= uses[p] + 1'b1;
          end else begin
            nxt[p] <= push_h;
            prv[p] <= NIL;
            if (push_h != NIL) prv[push_h[PIW-1:0]] <= LW'(p);
            head[push_t - 2'd1] <= LW'(p);
            tag[p] <= push_t;
            if (cmd == soa_pkg::C_LINK) fhead[p] <= chain_rdata;
          end
        end
        soa_pkg::C_WALK: begin
          if (st.walk_more) tag[cur[PIW-1:0]] <= soa_pkg::TAG_UNOWNED;
          else head[0] <= NIL;
        end
        default: ;
      endcase
    end
  end

  // Operation registers and the result being built.
  always_ff @(posedge clk) begin
    case (cmd)
      soa_pkg::C_LOAD: begin
        op  <= req.opcode;
        addr <= req.object_address;
        res <= '0;
        cur <= head[0];
        cnt <= '0;
      end
      soa_pkg::C_PICK: begin
        scan <= '0;
        if (have_slab) p <= pick;
        else if (n == '0) res.status <= soa_pkg::STATUS_NO_PAGE;
      end
      soa_pkg::C_SCAN: begin
        if (tag[scan] == soa_pkg::TAG_UNOWNED) begin
          p <= scan;
          j <= '0;
        end else if (st.scan_last) begin
          res.status <= soa_pkg::STATUS_NO_PAGE;
        end else begin
          scan <= scan + 1'b1;
        end
      end
      soa_pkg::C_CHAIN: j <= j + 1'b1;
      soa_pkg::C_POP: begin
        h <= fhead[p];
        if (pop_empty) res.status <= soa_pkg::STATUS_NO_PAGE;
      end
      soa_pkg::C_LINK: prod <= h * osz;
      soa_pkg::C_ADDR: begin
        res.allocated_address <= soa_pkg::ADDR_W'(32'(p) * PAGE_BYTES + 32'({n, 1'b0}) +
                                                  32'(prod));
      end
      soa_pkg::C_CHECK1: begin
        p <= qi;
        if (free_bad) res.status <= soa_pkg::STATUS_BAD_ADDR;
      end
      soa_pkg::C_CHECK2: begin
        slot <= dq[SW-1:0];
        if (st.slot_bad) res.status <= soa_pkg::STATUS_BAD_ADDR;
      end
      soa_pkg::C_WALK: begin
        if (st.walk_more) begin
          cnt <= cnt + 1'b1;
          cur <= nxt[cur[PIW-1:0]];
        end else begin
          res.slabs_released <= 5'(cnt);
        end
      end
      default: ;
    endcase
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd == soa_pkg::C_EMIT) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == soa_pkg::C_EMIT) rsp <= res;
  end

  always_comb begin
    st.opcode     = op;
    st.have_slab  = have_slab;
    st.n_zero     = n == '0;
    st.scan_hit   = tag[scan] == soa_pkg::TAG_UNOWNED;
    st.scan_last  = 32'(scan) == POOL_PAGES - 1;
    st.chain_last = chain_last;
    st.pop_empty  = pop_empty;
    st.div_busy   = div_busy;
    st.free_bad   = free_bad;
    st.slot_bad   = (dr != '0) || (dq >= 16'(n));
    st.walk_more  = (cur != NIL) && (32'(cnt) < POOL_PAGES);
    st.rsp_free   = rsp_free;
  end

endmodule
`default_nettype wire

FILE: rtl/slab_object_allocator_core.sv
// Slab object allocator for one object cache over a fixed pool of pages.
// Requests (opcode, object_address) arrive on req with req_valid/req_stall;
// one result word per request leaves on rsp with rsp_valid/rsp_stall.
// Opcode 0 allocates a slot, 1 frees the slot at object_address, 2 releases
// every page on the free list. Configuration writes (object_size at index 0,
// objects_per_slab at index 1) are always ready; the user is to let them go in
// only while idle, as the block itself does not enforce it. One request is
// worked on at a time; req_stall is high from acceptance until the result is
// placed in the output register. An allocate takes a slot from a partial or
// free slab, or grows by scanning for the lowest unowned page and chaining
// its slots. A free makes one pass through the 16-step divider unless it is
// rejected first on page, offset or a zero object_size. A shrink releases the
// pages on the free list one by one. A finished result waits in the output
// register while rsp_stall is high, and the next result is then held back
// until that word is taken.
// Reset clears all page ownership, empties the three page lists and restores
// object_size 16 and objects_per_slab 227; slot chain contents need no clear.
`default_nettype none
module slab_object_allocator_core #(
  parameter int POOL_PAGES = 16,
  parameter int PAGE_BYTES = 4096,
  parameter int MAX_SLOTS  = 2048
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire soa_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output soa_pkg::rsp_t      rsp,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic          cfg_index,
  input  wire logic [15:0]   cfg_data
);

  soa_pkg::cmd_t       cmd;
  soa_pkg::dp_status_t st;

  assign cfg_ready = 1'b1;

  soa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .st        (st),
    .req_stall (req_stall),
    .cmd       (cmd)
  );

  soa_dpath #(
    .POOL_PAGES (POOL_PAGES),
    .PAGE_BYTES (PAGE_BYTES),
    .MAX_SLOTS  (MAX_SLOTS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .req       (req),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request accepted but block not busy");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == soa_pkg::STATUS_OK ||
                   rsp.status == soa_pkg::STATUS_NO_PAGE ||
                   rsp.status == soa_pkg::STATUS_BAD_ADDR))
    else $error("undefined status code");

  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != soa_pkg::STATUS_OK) |->
      (rsp.allocated_address == '0 && rsp.slabs_released == '0))
    else $error("failed word carries an address or count");

endmodule
`default_nettype wire
